// ===== hw/rtl/afs_pkg.sv =====
// ----------------------------------------------------------------------------
// afs_pkg: shared types and constants of the APU frequency sweep unit
// Field widths, command and register codes, and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package afs_pkg;

  // Field widths
  localparam int unsigned FREQ_W     = 11;
  localparam int unsigned SUM_W      = FREQ_W + 1;
  localparam int unsigned TIMER_W    = 4;
  localparam int unsigned PERIOD_W   = 3;
  localparam int unsigned SHIFT_W    = 3;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  // Timer reload used when the period register is zero
  localparam logic [TIMER_W-1:0] ZERO_PERIOD_RELOAD = 4'd8;

  // Input item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_TRIGGER = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_ENABLE  = 2'd3
  } afs_cmd_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEGATE = 2'd2;

  // One result item
  typedef struct packed {
    logic [FREQ_W-1:0] frequency_now;
    logic              frequency_changed;
    logic              overflow_flag;
  } afs_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/apu_frequency_sweep_unit.sv =====
// A result item is registered in the output buffer once its input is accepted.
// Throughput: one item per cycle while the skid entry is free; the sweep update
// (shift, add, compare, and a second shift, add, compare on a tick) finishes
// within the accepting cycle. A two-entry output buffer keeps input acceptance
// going for one item while the result side stalls. Synchronous active-low reset
// clears frequency, timer, enable flag, configuration registers and both output entries.
// ----------------------------------------------------------------------------
// apu_frequency_sweep_unit: square-channel frequency sweep
// Keeps the 11-bit frequency, the sweep timer and the enable flag, and
// returns one result item per command item.
// ----------------------------------------------------------------------------
`default_nettype none

module apu_frequency_sweep_unit
  import afs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration write port
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [CMD_W-1:0]      in_command,
  input  wire logic [FREQ_W-1:0]     in_operand_value,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [FREQ_W-1:0]          out_frequency_now,
  output logic                       out_frequency_changed,
  output logic                       out_overflow_flag
);

  // Configuration registers
  logic [PERIOD_W-1:0] period_r;
  logic [SHIFT_W-1:0]  shift_r;
  logic                negate_r;

  // Sweep state
  logic [FREQ_W-1:0]  freq_r, freq_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic               enabled_r, enabled_nxt;

  // Output buffer
  afs_result_t out_r, skid_r, res;
  logic        out_valid_r, skid_valid_r;

  // Datapath intermediates
  logic [FREQ_W-1:0]  delta1, delta2, freq2;
  logic [SUM_W-1:0]   sum1, sum2;
  logic [TIMER_W-1:0] reload;
  logic               in_fire, out_fire;
  afs_cmd_t           cmd;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign cmd      = afs_cmd_t'(in_command);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      shift_r  <= '0;
      negate_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
        CFG_SHIFT:  shift_r  <= cfg_wdata[SHIFT_W-1:0];
        CFG_NEGATE: negate_r <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  // Form the swept value and the follow-up value for overflow checking
  always_comb begin
    delta1 = freq_r >> shift_r;
    sum1   = negate_r ? ({1'b0, freq_r} - {1'b0, delta1})
                      : ({1'b0, freq_r} + {1'b0, delta1});
    freq2  = sum1[FREQ_W-1:0];
    delta2 = freq2 >> shift_r;
    sum2   = negate_r ? ({1'b0, freq2} - {1'b0, delta2})
                      : ({1'b0, freq2} + {1'b0, delta2});
    reload = (period_r != '0) ? {1'b0, period_r} : ZERO_PERIOD_RELOAD;
  end

  // Decode the command and work out next state and result
  always_comb begin
    freq_nxt              = freq_r;
    timer_nxt             = timer_r;
    enabled_nxt           = enabled_r;
    res.frequency_changed = 1'b0;
    res.overflow_flag     = 1'b0;
    unique case (cmd)
      CMD_TICK: begin
        if (timer_r <= 4'd1) begin
          timer_nxt = reload;
          if (period_r != '0 && enabled_r) begin
            if (sum1[SUM_W-1]) begin
              res.overflow_flag = 1'b1;
            end else if (shift_r != '0) begin
              freq_nxt              = sum1[FREQ_W-1:0];
              res.frequency_changed = 1'b1;
              res.overflow_flag     = sum2[SUM_W-1];
            end
          end
        end else begin
          timer_nxt = timer_r - 4'd1;
        end
      end
      CMD_TRIGGER: begin
        timer_nxt = reload;
        if (shift_r != '0) begin
          if (sum1[SUM_W-1]) begin
            res.overflow_flag = 1'b1;
          end else begin
            freq_nxt              = sum1[FREQ_W-1:0];
            res.frequency_changed = 1'b1;
          end
        end
      end
      CMD_LOAD: begin
        freq_nxt = in_operand_value;
      end
      CMD_ENABLE: begin
        enabled_nxt = in_operand_value[0];
      end
      default: ;
    endcase
    res.frequency_now = freq_nxt;
  end

  // Advance sweep state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r    <= '0;
      timer_r   <= '0;
      enabled_r <= 1'b0;
    end else if (in_fire) begin
      freq_r    <= freq_nxt;
      timer_r   <= timer_nxt;
      enabled_r <= enabled_nxt;
    end
  end

  // Output buffer control: refill the head from the skid entry, else from input
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_fire || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (out_fire || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_frequency_now     = out_r.frequency_now;
  assign out_frequency_changed = out_r.frequency_changed;
  assign out_overflow_flag     = out_r.overflow_flag;

endmodule

`default_nettype wire

// ===== hw/rtl/afs_checker.sv =====
// ----------------------------------------------------------------------------
// afs_checker: port-level checks of the APU frequency sweep unit
// Watches reset, result stalls and command-specific result flags.
// ----------------------------------------------------------------------------
`default_nettype none

module afs_checker
  import afs_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [CMD_W-1:0]  in_command,
  input wire logic [FREQ_W-1:0] in_operand_value,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [FREQ_W-1:0] out_frequency_now,
  input wire logic              out_frequency_changed,
  input wire logic              out_overflow_flag
);

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frequency_now)
      && $stable(out_frequency_changed) && $stable(out_overflow_flag))
    else $error("stalled result changed");

  // A frequency load into an empty buffer shows up next cycle unchanged
  a_load_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid && in_command == CMD_LOAD |=>
      out_valid && out_frequency_now == $past(in_operand_value)
      && !out_frequency_changed && !out_overflow_flag)
    else $error("frequency load result wrong");

  // A trigger either stores a swept value or flags overflow, never both
  a_trigger_flags: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid && in_command == CMD_TRIGGER |=>
      out_valid && !(out_frequency_changed && out_overflow_flag))
    else $error("trigger result has both flags");

endmodule

bind apu_frequency_sweep_unit afs_checker u_afs_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .in_command            (in_command),
  .in_operand_value      (in_operand_value),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_frequency_now     (out_frequency_now),
  .out_frequency_changed (out_frequency_changed),
  .out_overflow_flag     (out_overflow_flag)
);

`default_nettype wire

// ===== dv/apu_frequency_sweep_unit_test.sv =====
// ----------------------------------------------------------------------------
// apu_frequency_sweep_unit_test: self-checking bench for the sweep unit
// Walks a table of directed commands and register writes, then runs phases of
// random commands under changing sweep settings and handshake idling. Every result
// item is checked field by field against an in-bench sweep predictor or a pinned expectation.
// ----------------------------------------------------------------------------
module apu_frequency_sweep_unit_test
  import afs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FREQ_LIMIT   = 2048;
  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          HOLD_CYCLES  = 60;
  localparam int          PHASES       = 10;
  localparam int          PHASE_ITEMS  = 125;
  localparam int          MAX_REPORTS  = 10;

  // Index past the last register; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {ROW_CFG, ROW_CMD, ROW_PINNED} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
    afs_cmd_t               cmd;
    logic [FREQ_W-1:0]      opnd;
    afs_result_t            want;
  } step_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_command = '0;
  logic [FREQ_W-1:0]     in_operand_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [FREQ_W-1:0]     out_frequency_now;
  logic                  out_frequency_changed;
  logic                  out_overflow_flag;

  // Typed-in expectation that travels with the item on the wire
  logic                  pin_on = 1'b0;
  afs_result_t           pin_want = '0;

  // Handshake pacing, percent of cycles
  int                    gap_pct = 0;
  int                    stall_pct = 0;
  int                    holds_asked = 0;
  int                    holds_served = 0;

  int                    cycle_count = 0;
  int                    mismatches = 0;
  afs_result_t           results_due [$];
  step_row_t             directed_rows [$];

  // Predicted sweep state and settings
  logic [FREQ_W-1:0]     pred_freq;
  logic [TIMER_W-1:0]    pred_countdown;
  logic                  pred_on;
  logic [PERIOD_W-1:0]   pred_period;
  logic [SHIFT_W-1:0]    pred_shift;
  logic                  pred_sub;

  apu_frequency_sweep_unit dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_operand_value      (in_operand_value),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_frequency_now     (out_frequency_now),
    .out_frequency_changed (out_frequency_changed),
    .out_overflow_flag     (out_overflow_flag)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Sweep predictor
  // ---------------------------------------------------------------------------
  function automatic logic [TIMER_W-1:0] countdown_reload();
    return (pred_period != 0) ? TIMER_W'(pred_period) : ZERO_PERIOD_RELOAD;
  endfunction

  // freq +/- (freq >> shift), one bit wider so overflow shows up
  function automatic logic [SUM_W-1:0] swept_sum();
    logic [FREQ_W-1:0] delta;
    delta = pred_freq >> pred_shift;
    if (pred_sub) return {1'b0, pred_freq} - {1'b0, delta};
    return {1'b0, pred_freq} + {1'b0, delta};
  endfunction

  function automatic afs_result_t apply_command(afs_cmd_t cmd, logic [FREQ_W-1:0] opnd);
    afs_result_t      res;
    logic [SUM_W-1:0] sum;
    res = '0;
    case (cmd)
      CMD_TICK: begin
        if (pred_countdown <= 1) begin
          pred_countdown = countdown_reload();
          if (pred_period != 0 && pred_on) begin
            sum = swept_sum();
            if (sum >= FREQ_LIMIT) begin
              res.overflow_flag = 1'b1;
            end else if (pred_shift != 0) begin
              pred_freq = sum[FREQ_W-1:0];
              res.frequency_changed = 1'b1;
              // Look one step ahead for overflow
              if (swept_sum() >= FREQ_LIMIT) res.overflow_flag = 1'b1;
            end
          end
        end else begin
          pred_countdown = pred_countdown - 1'b1;
        end
      end
      CMD_TRIGGER: begin
        pred_countdown = countdown_reload();
        if (pred_shift != 0) begin
          sum = swept_sum();
          if (sum >= FREQ_LIMIT) begin
            res.overflow_flag = 1'b1;
          end else begin
            pred_freq = sum[FREQ_W-1:0];
            res.frequency_changed = 1'b1;
          end
        end
      end
      CMD_LOAD: pred_freq = opnd;
      default: pred_on = opnd[0];
    endcase
    res.frequency_now = pred_freq;
    return res;
  endfunction

  function automatic void log_mismatch(string what, afs_result_t want, afs_result_t got);
    if (mismatches < MAX_REPORTS)
      $display("%s: want freq %0d chg %0b ovf %0b, got freq %0d chg %0b ovf %0b", what,
               want.frequency_now, want.frequency_changed, want.overflow_flag,
               got.frequency_now, got.frequency_changed, got.overflow_flag);
    mismatches++;
  endfunction

  // ---------------------------------------------------------------------------
  // Track register writes, predict on accepted items, check result items
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    afs_result_t want;
    afs_result_t got;
    if (!rst_n) begin
      pred_freq      = '0;
      pred_countdown = '0;
      pred_on        = 1'b0;
      pred_period    = '0;
      pred_shift     = '0;
      pred_sub       = 1'b0;
      results_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PERIOD: pred_period = cfg_wdata[PERIOD_W-1:0];
          CFG_SHIFT:  pred_shift  = cfg_wdata[SHIFT_W-1:0];
          CFG_NEGATE: pred_sub    = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = apply_command(afs_cmd_t'(in_command), in_operand_value);
        if (pin_on) want = pin_want;
        results_due.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {out_frequency_now, out_frequency_changed, out_overflow_flag};
        if (results_due.size() == 0) begin
          log_mismatch("unexpected result item", '0, got);
        end else begin
          want = results_due.pop_front();
          if (got !== want) log_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (holds_asked != holds_served) begin
        holds_served++;
        out_ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic step_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    step_row_t row;
    row = '0;
    row.kind     = ROW_CFG;
    row.reg_idx  = idx;
    row.reg_data = data;
    return row;
  endfunction

  function automatic step_row_t cmd_row(afs_cmd_t cmd, logic [FREQ_W-1:0] opnd);
    step_row_t row;
    row = '0;
    row.kind = ROW_CMD;
    row.cmd  = cmd;
    row.opnd = opnd;
    return row;
  endfunction

  function automatic step_row_t pinned_row(afs_cmd_t cmd, logic [FREQ_W-1:0] opnd,
                                           logic [FREQ_W-1:0] freq, logic chg, logic ovf);
    step_row_t row;
    row      = cmd_row(cmd, opnd);
    row.kind = ROW_PINNED;
    row.want = {freq, chg, ovf};
    return row;
  endfunction

  // Offer one item, idling first at the sender's rate; return at acceptance
  task automatic offer_item(input afs_cmd_t cmd, input logic [FREQ_W-1:0] opnd,
                            input logic pinned, input afs_result_t want);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_operand_value <= opnd;
    pin_on           <= pinned;
    pin_want         <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the input and wait until every result item has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    afs_cmd_t          cmd;
    logic [FREQ_W-1:0] opnd;
    int                pick;

    directed_rows = '{
      // Out of reset: timer expires but nothing is swept
      pinned_row(CMD_TICK,    11'd0,    11'd0,    1'b0, 1'b0),
      pinned_row(CMD_LOAD,    11'd2047, 11'd2047, 1'b0, 1'b0),
      pinned_row(CMD_TRIGGER, 11'd0,    11'd2047, 1'b0, 1'b0),
      pinned_row(CMD_ENABLE,  11'd2047, 11'd2047, 1'b0, 1'b0),
      cfg_row(CFG_SHIFT, 3'd1),
      cfg_row(CFG_PERIOD, 3'd1),
      // Top frequency overflows on trigger and on tick
      pinned_row(CMD_TRIGGER, 11'd2047, 11'd2047, 1'b0, 1'b1),
      pinned_row(CMD_TICK,    11'd0,    11'd2047, 1'b0, 1'b1),
      pinned_row(CMD_LOAD,    11'd1000, 11'd1000, 1'b0, 1'b0),
      // Stored value whose look-ahead overflows: both flags
      pinned_row(CMD_TICK,    11'd0,    11'd1500, 1'b1, 1'b1),
      cmd_row(CMD_LOAD, 11'd100),
      cmd_row(CMD_TICK, 11'd0),
      cfg_row(CFG_NEGATE, 3'd1),
      cfg_row(CFG_SHIFT, 3'd7),
      cfg_row(CFG_PERIOD, 3'd7),
      cmd_row(CMD_TRIGGER, 11'd2047),
      cmd_row(CMD_TICK, 11'd2047),
      // Subtract with zero shift: computed but never stored
      cfg_row(CFG_SHIFT, 3'd0),
      cfg_row(CFG_PERIOD, 3'd1),
      cmd_row(CMD_TRIGGER, 11'd0),
      pinned_row(CMD_TICK,    11'd0,    11'd149,  1'b0, 1'b0),
      pinned_row(CMD_ENABLE,  11'h7FE,  11'd149,  1'b0, 1'b0),
      // Upper data bits dropped, unused index ignored
      cfg_row(CFG_SHIFT, 3'd2),
      cfg_row(CFG_NEGATE, 3'b110),
      cfg_row(CFG_UNUSED, 3'd7),
      // Trigger sweeps even while disabled; tick does not
      cmd_row(CMD_TRIGGER, 11'd0),
      cmd_row(CMD_TICK, 11'd0),
      pinned_row(CMD_LOAD,    11'd0,    11'd0,    1'b0, 1'b0),
      cmd_row(CMD_ENABLE, 11'd1),
      cmd_row(CMD_TRIGGER, 11'd0)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        offer_item(directed_rows[i].cmd, directed_rows[i].opnd,
                   directed_rows[i].kind == ROW_PINNED, directed_rows[i].want);
      end
    end

    // Random phases
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase % 4)
        0: begin gap_pct <= 0;  stall_pct <= 0;  end
        1: begin gap_pct <= 77; stall_pct <= 0;  end
        2: begin gap_pct <= 0;  stall_pct <= 77; end
        default: begin gap_pct <= 14; stall_pct <= 14; end
      endcase
      // Settings: the two extremes, a fast-overflow corner, then random
      if (phase == 0) begin
        write_reg(CFG_PERIOD, 3'd7);
        write_reg(CFG_SHIFT, 3'd7);
        write_reg(CFG_NEGATE, 3'd7);
      end else if (phase == 1) begin
        write_reg(CFG_PERIOD, 3'd0);
        write_reg(CFG_SHIFT, 3'd0);
        write_reg(CFG_NEGATE, 3'd0);
      end else if (phase == 2) begin
        write_reg(CFG_PERIOD, 3'd1);
        write_reg(CFG_SHIFT, 3'd1);
        write_reg(CFG_NEGATE, 3'd0);
      end else begin
        write_reg(CFG_PERIOD, CFG_DATA_W'($urandom));
        write_reg(CFG_SHIFT, CFG_DATA_W'($urandom));
        write_reg(CFG_NEGATE, CFG_DATA_W'($urandom));
        if ($urandom_range(1) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Long result hold-off while items keep coming
        if ((phase == 2 || phase == 6) && n == 30) holds_asked <= holds_asked + 1;
        // Let the pipe run dry mid-phase
        if (phase == 5 && n == 60) drain_results();

        pick = $urandom_range(99);
        opnd = FREQ_W'($urandom);
        if (pick < 50) begin
          cmd = CMD_TICK;
        end else if (pick < 65) begin
          cmd = CMD_TRIGGER;
        end else if (pick < 85) begin
          cmd = CMD_LOAD;
          if ($urandom_range(2) == 0) opnd = FREQ_W'($urandom_range(511));
        end else begin
          cmd = CMD_ENABLE;
          if ($urandom_range(3) != 0) opnd[0] = 1'b1;
        end
        offer_item(cmd, opnd, 1'b0, '0);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
